// ----- sv/hpte_pkg.sv -----
// ----------------------------------------------------------------------------
// Hashed page table engine package
// Shared codes, payload constants and the controller/datapath link types.
// ----------------------------------------------------------------------------
package hpte_pkg;

   localparam int DEF_BUCKETS   = 1024;
   localparam int DEF_ENTRIES   = 1024;
   localparam int DEF_VPN_BITS  = 20;
   localparam int DEF_ASID_BITS = 8;

   localparam int PFN_BITS         = 20;
   localparam int DATA_BITS        = 23;
   localparam int FLAG_NOCACHE_BIT = 20;
   localparam int FLAG_DIRTY_BIT   = 21;
   localparam int FLAG_VALID_BIT   = 22;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_REQ   = 2'd1,
      SRC_ENTRY = 2'd2
   } resp_src_type;

   typedef struct packed {
      logic         accept;
      logic         clear_wr;
      logic         rd_from_head;
      logic         rd_from_next;
      logic         load_head;
      logic         advance;
      logic         ins_alloc;
      logic         ins_head_wr;
      logic         ins_tail_wr;
      logic         del_unlink;
      logic         resp_load;
      status_type   resp_status;
      resp_src_type resp_src;
   } cmd_type;

   typedef struct packed {
      logic       hash_done;
      logic       clear_last;
      logic       out_free;
      logic       head_nil;
      logic       next_nil;
      logic       key_hit;
      logic       hit_valid;
      logic       pool_empty;
      logic [1:0] action;
   } sts_type;

endpackage

// ----- sv/hpte_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request item.
// ----------------------------------------------------------------------------
interface hpte_req_if #(
   parameter int ASID_BITS = 8,
   parameter int VPN_BITS  = 20
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [ASID_BITS-1:0] asid;
   logic [VPN_BITS-1:0]  vpn;
   logic [19:0]          pfn;
   logic                 nocache;
   logic                 dirty;
   logic                 valid_in;

   modport source (output valid, action, asid, vpn, pfn, nocache, dirty, valid_in,
                   input ready);
   modport sink   (input valid, action, asid, vpn, pfn, nocache, dirty, valid_in,
                   output ready);
endinterface

// ----- sv/hpte_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one table result item.
// ----------------------------------------------------------------------------
interface hpte_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [19:0] frame;
   logic        flag_nocache;
   logic        flag_dirty;
   logic        flag_valid;

   modport source (output valid, status, frame, flag_nocache, flag_dirty, flag_valid,
                   input ready);
   modport sink   (input valid, status, frame, flag_nocache, flag_dirty, flag_valid,
                   output ready);
endinterface

// ----- sv/hpte_dp.sv -----
// ----------------------------------------------------------------------------
// Hashed page table datapath
// Bucket hash, head/entry/free-stack memories, chain pointers, result register.
// ----------------------------------------------------------------------------
module hpte_dp
   import hpte_pkg::*;
#(
   parameter int BUCKETS   = DEF_BUCKETS,
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int VPN_BITS  = DEF_VPN_BITS,
   parameter int ASID_BITS = DEF_ASID_BITS
) (
   input  logic        clock,
   input  logic        reset,
   hpte_req_if.sink    req,
   hpte_rsp_if.source  rsp,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int KW       = ASID_BITS + VPN_BITS;
   localparam int XW       = (ASID_BITS > VPN_BITS) ? ASID_BITS : VPN_BITS;
   localparam int BIDX     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int XP       = (((XW > BIDX) ? XW : BIDX) + 3) / 4 * 4;
   localparam int STEPS    = XP / 4;
   localparam int CW       = $clog2(STEPS + 1);
   localparam int PW       = $clog2(ENTRIES + 1);
   localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);

   logic [1:0]           action_ff;
   logic [KW-1:0]        key_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [XP-1:0]        x_ff, x_in;
   logic [BIDX-1:0]      r_ff, r_in;
   logic [CW-1:0]        hcnt_ff;
   logic [BIDX:0]        t;
   logic [BIDX-1:0]      bucket;

   logic [PW-1:0]        head_mem [BUCKETS];
   logic [KW-1:0]        key_mem  [ENTRIES];
   logic [DATA_BITS-1:0] data_mem [ENTRIES];
   logic [PW-1:0]        next_mem [ENTRIES];
   logic [AW-1:0]        free_mem [ENTRIES];

   logic [PW-1:0]        head_rd_ff, next_rd_ff;
   logic [KW-1:0]        key_rd_ff;
   logic [DATA_BITS-1:0] data_rd_ff;
   logic [AW-1:0]        free_rd_ff;

   logic [PW-1:0]        cur_ff, prev_ff, rd_ptr;
   logic [AW-1:0]        e_ff, alloc;
   logic [PW-1:0]        count_ff, low_ff, cnt_m1, fresh;
   logic [BIDX-1:0]      clr_ff;
   logic                 prev_nil;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;

   assign x_in = XP'(req.asid) ^ XP'(req.vpn);

   always_comb begin
      t = {1'b0, r_ff};
      for (int i = 0; i < 4; i++) begin
         t = {t[BIDX-1:0], x_ff[XP-1-i]};
         if (t >= (BIDX+1)'(BUCKETS)) begin
            t = t - (BIDX+1)'(BUCKETS);
         end
      end
      r_in = t[BIDX-1:0];
   end

   assign bucket = BKT_POW2 ? (x_ff[BIDX-1:0] & BIDX'(BUCKETS - 1)) : r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff <= '0;
      end else if (cmd.accept) begin
         hcnt_ff <= CW'(STEPS);
      end else if (hcnt_ff != '0) begin
         hcnt_ff <= hcnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req.action;
         key_ff    <= {req.asid, req.vpn};
         data_ff   <= {req.valid_in, req.dirty, req.nocache, req.pfn};
         x_ff      <= x_in;
         r_ff      <= '0;
      end else if (!BKT_POW2 && hcnt_ff != '0) begin
         x_ff <= x_ff << 4;
         r_ff <= r_in;
      end
   end

   assign cnt_m1 = count_ff - PW'(1);
   assign fresh  = NIL - count_ff;
   assign alloc  = (count_ff <= low_ff) ? fresh[AW-1:0] : free_rd_ff;
   assign prev_nil = (prev_ff == NIL);

   always_comb begin
      if (cmd.rd_from_head) begin
         rd_ptr = head_rd_ff;
      end else if (cmd.rd_from_next) begin
         rd_ptr = next_rd_ff;
      end else begin
         rd_ptr = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= NIL;
         low_ff   <= NIL;
         clr_ff   <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + BIDX'(1);
         end
         if (cmd.ins_alloc) begin
            count_ff <= cnt_m1;
            if (count_ff <= low_ff) begin
               low_ff <= cnt_m1;
            end
         end else if (cmd.del_unlink) begin
            count_ff <= count_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_alloc) begin
         e_ff <= alloc;
      end
      if (cmd.load_head) begin
         cur_ff  <= head_rd_ff;
         prev_ff <= NIL;
      end else if (cmd.advance) begin
         cur_ff  <= next_rd_ff;
         prev_ff <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         head_mem[clr_ff] <= NIL;
      end else if (cmd.ins_head_wr) begin
         head_mem[bucket] <= PW'(alloc);
      end else if (cmd.del_unlink && prev_nil) begin
         head_mem[bucket] <= next_rd_ff;
      end
      head_rd_ff <= head_mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_alloc) begin
         key_mem[alloc]  <= key_ff;
         data_mem[alloc] <= data_ff;
      end
      key_rd_ff  <= key_mem[rd_ptr[AW-1:0]];
      data_rd_ff <= data_mem[rd_ptr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_alloc) begin
         next_mem[alloc] <= NIL;
      end else if (cmd.ins_tail_wr) begin
         next_mem[cur_ff[AW-1:0]] <= PW'(e_ff);
      end else if (cmd.del_unlink && !prev_nil) begin
         next_mem[prev_ff[AW-1:0]] <= next_rd_ff;
      end
      next_rd_ff <= next_mem[rd_ptr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.del_unlink) begin
         free_mem[count_ff[AW-1:0]] <= cur_ff[AW-1:0];
      end
      free_rd_ff <= free_mem[cnt_m1[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_status_ff <= cmd.resp_status;
         case (cmd.resp_src)
            SRC_REQ:   rsp_data_ff <= data_ff;
            SRC_ENTRY: rsp_data_ff <= data_rd_ff;
            default:   rsp_data_ff <= '0;
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.frame        = rsp_data_ff[PFN_BITS-1:0];
   assign rsp.flag_nocache = rsp_data_ff[FLAG_NOCACHE_BIT];
   assign rsp.flag_dirty   = rsp_data_ff[FLAG_DIRTY_BIT];
   assign rsp.flag_valid   = rsp_data_ff[FLAG_VALID_BIT];

   assign sts.hash_done  = BKT_POW2 || (hcnt_ff == '0);
   assign sts.clear_last = (clr_ff == BIDX'(BUCKETS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp.ready;
   assign sts.head_nil   = (head_rd_ff == NIL);
   assign sts.next_nil   = (next_rd_ff == NIL);
   assign sts.key_hit    = (key_rd_ff == key_ff);
   assign sts.hit_valid  = data_rd_ff[FLAG_VALID_BIT];
   assign sts.pool_empty = (count_ff == '0);
   assign sts.action     = action_ff;

endmodule

// ----- sv/hpte_ctrl.sv -----
// ----------------------------------------------------------------------------
// Hashed page table controller
// Sequences head clearing, hashing, head fetch and the chain walk.
// ----------------------------------------------------------------------------
module hpte_ctrl
   import hpte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_LOOK,
      S_CHK
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.hash_done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            if (sts.out_free) begin
               case (sts.action)
                  ACT_INSERT: begin
                     if (sts.pool_empty) begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_status = ST_FULL;
                        cmd.resp_src    = SRC_ZERO;
                        state_in        = S_IDLE;
                     end else begin
                        cmd.ins_alloc = 1'b1;
                        if (sts.head_nil) begin
                           cmd.ins_head_wr = 1'b1;
                           cmd.resp_load   = 1'b1;
                           cmd.resp_status = ST_DONE;
                           cmd.resp_src    = SRC_REQ;
                           state_in        = S_IDLE;
                        end else begin
                           cmd.rd_from_head = 1'b1;
                           cmd.load_head    = 1'b1;
                           state_in         = S_CHK;
                        end
                     end
                  end
                  ACT_DELETE, ACT_LOOKUP: begin
                     if (sts.head_nil) begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_status = ST_NOTFOUND;
                        cmd.resp_src    = SRC_ZERO;
                        state_in        = S_IDLE;
                     end else begin
                        cmd.rd_from_head = 1'b1;
                        cmd.load_head    = 1'b1;
                        state_in         = S_CHK;
                     end
                  end
                  default: begin
                     cmd.resp_load   = 1'b1;
                     cmd.resp_status = ST_NOTFOUND;
                     cmd.resp_src    = SRC_ZERO;
                     state_in        = S_IDLE;
                  end
               endcase
            end
         end
         S_CHK: begin
            if (sts.out_free) begin
               if (sts.action == ACT_INSERT) begin
                  if (sts.next_nil) begin
                     cmd.ins_tail_wr = 1'b1;
                     cmd.resp_load   = 1'b1;
                     cmd.resp_status = ST_DONE;
                     cmd.resp_src    = SRC_REQ;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.rd_from_next = 1'b1;
                     cmd.advance      = 1'b1;
                  end
               end else if (sts.key_hit &&
                            (sts.action == ACT_DELETE || sts.hit_valid)) begin
                  cmd.del_unlink  = (sts.action == ACT_DELETE);
                  cmd.resp_load   = 1'b1;
                  cmd.resp_status = ST_DONE;
                  cmd.resp_src    = SRC_ENTRY;
                  state_in        = S_IDLE;
               end else if (sts.next_nil) begin
                  cmd.resp_load   = 1'b1;
                  cmd.resp_status = ST_NOTFOUND;
                  cmd.resp_src    = SRC_ZERO;
                  state_in        = S_IDLE;
               end else begin
                  cmd.rd_from_next = 1'b1;
                  cmd.advance      = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/hashed_page_table_engine.sv -----
// ----------------------------------------------------------------------------
// Hashed page table engine
// Handles one insert, delete or lookup item at a time. After reset the
// bucket head memory is swept clear, one bucket per cycle, before the
// first item is taken. An item then passes through the accept, the bucket
// hash (the low bits when BUCKETS is a power of two, otherwise a modulo
// reduction taking four bits of the asid XOR vpn per step), the registered
// head fetch and the chain walk, where each entry visited waits on the
// registered read of the entry memories. The result register lets the
// next item start while a result waits to be taken; that item holds in
// its head check or chain step until the waiting result is taken.
// ----------------------------------------------------------------------------
module hashed_page_table_engine
   import hpte_pkg::*;
#(
   parameter int BUCKETS   = DEF_BUCKETS,
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int VPN_BITS  = DEF_VPN_BITS,
   parameter int ASID_BITS = DEF_ASID_BITS
) (
   input logic        clock,
   input logic        reset,
   hpte_req_if.sink   req_chan,
   hpte_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;
   logic    ready;

   assign req_chan.ready = ready;

   hpte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hpte_dp #(
      .BUCKETS   (BUCKETS),
      .ENTRIES   (ENTRIES),
      .VPN_BITS  (VPN_BITS),
      .ASID_BITS (ASID_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

// ----- tb/hpte_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench table sizes
// Bucket and entry counts that the bench table model is built for.
// ----------------------------------------------------------------------------
package hpte_tb_pkg;

   localparam int TB_ENTRIES = 1024;
   localparam int TB_BUCKETS = 1024;

endpackage

// ----- tb/hashed_page_table_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hashed page table engine testbench
// Drives insert, delete, lookup and undefined-action items through the request
// channel with random gaps, predicts every result from a chained-bucket table
// model kept here, and compares each response field by field in order.
// ----------------------------------------------------------------------------
module hashed_page_table_engine_tb;
   import hpte_pkg::*;
   import hpte_tb_pkg::*;

   localparam int NIL = TB_ENTRIES;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      status_type  status;
      logic [19:0] frame;
      logic        nocache;
      logic        dirty;
      logic        valid;
   } table_result_type;

   logic clock;
   logic reset;

   hpte_req_if #(.ASID_BITS(8), .VPN_BITS(20)) req_chan ();
   hpte_rsp_if rsp_chan ();

   hashed_page_table_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   int          head_of[TB_BUCKETS];
   logic [27:0] key_of[TB_ENTRIES];
   logic [22:0] data_of[TB_ENTRIES];
   int          next_of[TB_ENTRIES];
   int          free_stack[TB_ENTRIES];
   int          free_count;

   table_result_type expected_results[$];
   int  mismatches;
   int  results_seen;
   int  items_sent;
   int  full_seen;
   int  hits_seen;
   longint cycles;
   bit  stall_long;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[hashed_page_table_engine] ERROR");
         $finish;
      end
   end

   function automatic table_result_type make_result(status_type st, logic [22:0] d);
      table_result_type r;
      r.status  = st;
      r.frame   = d[19:0];
      r.nocache = d[FLAG_NOCACHE_BIT];
      r.dirty   = d[FLAG_DIRTY_BIT];
      r.valid   = d[FLAG_VALID_BIT];
      return r;
   endfunction

   task automatic clear_table();
      for (int i = 0; i < TB_BUCKETS; i++) head_of[i] = NIL;
      for (int i = 0; i < TB_ENTRIES; i++) begin
         next_of[i]    = NIL;
         free_stack[i] = TB_ENTRIES - 1 - i;
      end
      free_count = TB_ENTRIES;
   endtask

   function automatic table_result_type predict_table(logic [1:0] act, logic [7:0] asid,
         logic [19:0] vpn, logic [19:0] pfn, logic nc, logic dt, logic vl);
      logic [27:0] key;
      int b, cur, prev, e;
      logic [22:0] d;
      key = {asid, vpn};
      b   = int'(({12'd0, asid} ^ vpn) % TB_BUCKETS);
      case (act)
         ACT_INSERT: begin
            if (free_count == 0) return make_result(ST_FULL, '0);
            free_count--;
            e = free_stack[free_count];
            d = {vl, dt, nc, pfn};
            key_of[e]  = key;
            data_of[e] = d;
            next_of[e] = NIL;
            if (head_of[b] == NIL) begin
               head_of[b] = e;
            end else begin
               cur = head_of[b];
               while (next_of[cur] != NIL) cur = next_of[cur];
               next_of[cur] = e;
            end
            return make_result(ST_DONE, d);
         end
         ACT_DELETE: begin
            prev = NIL;
            cur  = head_of[b];
            while (cur != NIL) begin
               if (key_of[cur] == key) begin
                  if (prev == NIL) head_of[b] = next_of[cur];
                  else next_of[prev] = next_of[cur];
                  next_of[cur] = NIL;
                  free_stack[free_count] = cur;
                  free_count++;
                  return make_result(ST_DONE, data_of[cur]);
               end
               prev = cur;
               cur  = next_of[cur];
            end
            return make_result(ST_NOTFOUND, '0);
         end
         ACT_LOOKUP: begin
            cur = head_of[b];
            while (cur != NIL) begin
               if (key_of[cur] == key && data_of[cur][FLAG_VALID_BIT])
                  return make_result(ST_DONE, data_of[cur]);
               cur = next_of[cur];
            end
            return make_result(ST_NOTFOUND, '0);
         end
         default: return make_result(ST_NOTFOUND, '0);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(logic [1:0] act, logic [7:0] asid, logic [19:0] vpn,
         logic [19:0] pfn, logic nc, logic dt, logic vl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.action   <= act;
      req_chan.asid     <= asid;
      req_chan.vpn      <= vpn;
      req_chan.pfn      <= pfn;
      req_chan.nocache  <= nc;
      req_chan.dirty    <= dt;
      req_chan.valid_in <= vl;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_table(act, asid, vpn, pfn, nc, dt, vl));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_random(logic [1:0] act, logic [7:0] asid, logic [19:0] vpn);
      send_request(act, asid, vpn, 20'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom_range(0, 5) != 0));
   endtask

   // response side: random stall with occasional long stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_long <= ~stall_long;
         if (stall_long) rsp_chan.ready <= ($urandom_range(0, 15) == 0);
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      table_result_type exp_r, got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status  = status_type'(rsp_chan.status);
         got.frame   = rsp_chan.frame;
         got.nocache = rsp_chan.flag_nocache;
         got.dirty   = rsp_chan.flag_dirty;
         got.valid   = rsp_chan.flag_valid;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            exp_r = expected_results.pop_front();
            if (got.status == ST_FULL) full_seen++;
            if (got.status == ST_DONE) hits_seen++;
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", exp_r, got);
            end
         end
      end
   end

   task automatic test_directed();
      send_request(ACT_LOOKUP, 8'h00, 20'h00000, '0, 0, 0, 0);
      send_request(ACT_DELETE, 8'hFF, 20'hFFFFF, '0, 0, 0, 0);
      send_request(ACT_INSERT, 8'h00, 20'h00000, 20'hFFFFF, 1, 1, 1);
      send_request(ACT_INSERT, 8'hFF, 20'hFFFFF, 20'h00000, 0, 0, 1);
      send_request(ACT_INSERT, 8'h12, 20'h00012, 20'h5A5A5, 1, 0, 0);
      send_request(ACT_LOOKUP, 8'h12, 20'h00012, '0, 0, 0, 0);
      send_request(ACT_INSERT, 8'h12, 20'h00012, 20'hA5A5A, 0, 1, 1);
      send_request(ACT_LOOKUP, 8'h12, 20'h00012, '0, 0, 0, 0);
      send_request(ACT_INSERT, 8'h12, 20'h00012, 20'h11111, 1, 1, 1);
      send_request(ACT_LOOKUP, 8'h00, 20'h00000, '0, 0, 0, 0);
      send_request(ACT_LOOKUP, 8'hFF, 20'hFFFFF, 20'hFFFFF, 1, 1, 1);
      send_request(ACT_DELETE, 8'h12, 20'h00012, '0, 0, 0, 0);
      send_request(ACT_LOOKUP, 8'h12, 20'h00012, '0, 0, 0, 0);
      send_request(ACT_DELETE, 8'h12, 20'h00012, '0, 0, 0, 0);
      send_request(ACT_LOOKUP, 8'h12, 20'h00012, '0, 0, 0, 0);
      send_request(2'd3, 8'h00, 20'h00000, 20'hFFFFF, 1, 1, 1);
      send_request(ACT_DELETE, 8'h00, 20'h00000, '0, 0, 0, 0);
      send_request(ACT_DELETE, 8'h00, 20'h00000, '0, 0, 0, 0);
   endtask

   // fill the pool through few buckets so chains grow long, overflow it, then mix lookups, deletes and inserts
   task automatic test_pool_full();
      int base;
      base = items_sent;
      while (free_count > 0) send_random(ACT_INSERT, 8'($urandom_range(0, 7)),
                                         20'($urandom_range(0, 63)));
      repeat (4) send_random(ACT_INSERT, 8'($urandom), 20'($urandom));
      repeat (40) send_random(ACT_LOOKUP, 8'($urandom_range(0, 7)),
                              20'($urandom_range(0, 63)));
      repeat (30) send_random(ACT_DELETE, 8'($urandom_range(0, 7)),
                              20'($urandom_range(0, 63)));
      repeat (3) send_random(ACT_INSERT, 8'($urandom), 20'($urandom));
      for (int i = 0; i < 40 && items_sent - base < 1400; i++)
         send_random(ACT_DELETE, 8'($urandom_range(0, 7)), 20'($urandom_range(0, 63)));
   endtask

   task automatic test_random_mix();
      logic [7:0]  ka[32];
      logic [19:0] kv[32];
      int k, r;
      for (int i = 0; i < 32; i++) begin
         ka[i] = 8'($urandom);
         kv[i] = (i < 16) ? 20'(ka[0] ^ {12'd0, ka[i]}) : 20'($urandom);
      end
      for (int n = 0; n < 700; n++) begin
         k = $urandom_range(0, 31);
         r = $urandom_range(0, 99);
         if (r < 5)
            send_request(2'($urandom), 8'($urandom), 20'($urandom), 20'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 40) send_random(ACT_INSERT, ka[k], kv[k]);
         else if (r < 65) send_random(ACT_DELETE, ka[k], kv[k]);
         else send_random(ACT_LOOKUP, ka[k], kv[k]);
      end
   endtask

   initial begin
      int drain;
      cycles     = 0;
      mismatches = 0;
      results_seen = 0;
      items_sent = 0;
      full_seen  = 0;
      hits_seen  = 0;
      stall_long = 1'b0;
      reset      = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.action   = ACT_INSERT;
      req_chan.asid     = '0;
      req_chan.vpn      = '0;
      req_chan.pfn      = '0;
      req_chan.nocache  = 1'b0;
      req_chan.dirty    = 1'b0;
      req_chan.valid_in = 1'b0;
      rsp_chan.ready    = 1'b0;
      clear_table();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_pool_full();
      test_random_mix();
      req_chan.valid <= 1'b0;

      drain = 0;
      while (expected_results.size() != 0 && drain < 200000) begin
         @(posedge clock);
         drain++;
      end
      repeat (50) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches++;
         $display("%0d results never arrived", expected_results.size());
      end
      $display("sent %0d items, checked %0d results (%0d done, %0d table full)",
               items_sent, results_seen, hits_seen, full_seen);
      if (mismatches == 0) begin
         $display("[hashed_page_table_engine] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[hashed_page_table_engine] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/hpte_pkg.sv
sv/hpte_req_if.sv
sv/hpte_rsp_if.sv
sv/hpte_dp.sv
sv/hpte_ctrl.sv
sv/hashed_page_table_engine.sv
tb/hpte_tb_if.sv
tb/hashed_page_table_engine_tb.sv
